### src/button_click_hold_double_detector_core_assert.svh
// Assertion macros of the button qualifier top level
`ifndef BUTTON_CLICK_HOLD_DOUBLE_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DOUBLE_DETECTOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked on every clock edge outside reset
`define BCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);
// checked on every clock edge, reset included
`define BCD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCD_ASSERT(lbl, prop, msg)
`define BCD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/bcd_pkg.sv
// Types and constants of the button qualifier
package bcd_pkg;

	// transfer kinds
	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DEBOUNCE       = 2'd0,
		REG_HOLD           = 2'd1,
		REG_DOUBLE_WAIT    = 2'd2,
		REG_DOUBLE_CONFIRM = 2'd3
	} reg_idx_t;

	// button roles
	typedef enum logic [1:0] {
		BTN_SOURCE = 2'd0,
		BTN_EQ     = 2'd1,
		BTN_AGC    = 2'd2,
		BTN_MODE   = 2'd3
	} button_t;

	// audio source codes
	localparam logic [1:0] SRC_USB = 2'd0;
	localparam logic [1:0] SRC_AUX = 2'd1;
	localparam logic [1:0] SRC_BT  = 2'd2;

	localparam int CFG_DATA_W = 10;
	localparam int CNT_W      = 10;

	// register reset values
	localparam logic [7:0] DEBOUNCE_RST       = 8'd50;
	localparam logic [8:0] HOLD_RST           = 9'd120;
	localparam logic [9:0] DOUBLE_WAIT_RST    = 10'd450;
	localparam logic [9:0] DOUBLE_CONFIRM_RST = 10'd500;

	typedef struct packed {
		logic [7:0] debounce_ticks;
		logic [8:0] hold_ticks;
		logic [9:0] double_wait_end;
		logic [9:0] double_confirm_end;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] button;
		logic [3:0] levels;
	} item_t;

	typedef struct packed {
		logic [1:0] audio_source;
		logic       source_changed;
		logic       eq_enabled;
		logic       agc_enabled;
		logic       agc_run;
		logic       next_mode;
		logic       next_theme;
		logic       busy_res;
	} result_t;

endpackage

### src/bcd_cfg.sv
// Configuration register file of the button qualifier
module bcd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [bcd_pkg::CFG_DATA_W-1:0] cfg_data,
	output bcd_pkg::cfg_t                cfg
);
	import bcd_pkg::*;

	cfg_t cfg_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
			cfg_q.hold_ticks         <= HOLD_RST;
			cfg_q.double_wait_end    <= DOUBLE_WAIT_RST;
			cfg_q.double_confirm_end <= DOUBLE_CONFIRM_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE:       cfg_q.debounce_ticks     <= cfg_data[7:0];
				REG_HOLD:           cfg_q.hold_ticks         <= cfg_data[8:0];
				REG_DOUBLE_WAIT:    cfg_q.double_wait_end    <= cfg_data[9:0];
				REG_DOUBLE_CONFIRM: cfg_q.double_confirm_end <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/bcd_fsm.sv
// Qualifier state and its per-transfer update
module bcd_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  bcd_pkg::item_t   item,
	input  bcd_pkg::cfg_t    cfg,
	output bcd_pkg::result_t res
);
	import bcd_pkg::*;

	logic             busy_q, n_busy;
	logic [1:0]       btn_q, n_btn;
	logic [CNT_W-1:0] cnt_q, n_cnt;
	logic [1:0]       src_q, n_src;
	logic             eq_q, n_eq;
	logic             agc_dis_q, n_agc_dis;
	logic             agc_act_q, n_agc_act;
	logic             chg, mode_p, theme_p;

	logic             pressed;
	logic [CNT_W-1:0] d, h, w, c, h1, d1, cnt_inc;

	// thresholds widened to the counter
	assign d       = {2'b00, cfg.debounce_ticks};
	assign h       = {1'b0, cfg.hold_ticks};
	assign w       = cfg.double_wait_end;
	assign c       = cfg.double_confirm_end;
	assign h1      = h + 10'd1;
	assign d1      = d + 10'd1;
	assign cnt_inc = cnt_q + 10'd1;
	assign pressed = item.levels[btn_q];

	// next state for one transfer
	always_comb begin
		n_busy    = busy_q;
		n_btn     = btn_q;
		n_cnt     = cnt_q;
		n_src     = src_q;
		n_eq      = eq_q;
		n_agc_dis = agc_dis_q;
		n_agc_act = agc_act_q;
		chg       = 1'b0;
		mode_p    = 1'b0;
		theme_p   = 1'b0;
		if (item.kind == KIND_EDGE) begin
			// latch the button only when idle
			if (!busy_q) begin
				n_busy = 1'b1;
				n_btn  = item.button;
				n_cnt  = '0;
			end
		end else if (busy_q) begin
			case (button_t'(btn_q))
				BTN_AGC: begin
					if (cnt_q < d) begin
						if (pressed) begin
							n_cnt = cnt_inc;
						end else begin
							n_agc_act = 1'b0;
							n_busy    = 1'b0;
							n_btn     = '0;
							n_cnt     = '0;
						end
					end else if (cnt_q < h) begin
						if (pressed) begin
							n_cnt = cnt_inc;
							if (cnt_inc >= h && !agc_dis_q)
								n_agc_act = 1'b1;
						end else begin
							n_agc_act = 1'b0;
							n_cnt     = h1;
						end
					end else if (cnt_q == h) begin
						if (pressed) begin
							n_agc_act = !agc_dis_q;
						end else begin
							n_agc_act = 1'b0;
							n_cnt     = h1;
						end
					end else if (cnt_q < w) begin
						if (pressed) begin
							n_cnt = w;
						end else begin
							n_cnt = cnt_inc;
							if (cnt_inc >= w) begin
								n_agc_act = 1'b0;
								n_busy    = 1'b0;
								n_btn     = '0;
								n_cnt     = '0;
							end
						end
					end else if (cnt_q < c) begin
						if (pressed) begin
							n_cnt = cnt_inc;
							// second press held long enough: double click
							if (cnt_inc >= c) begin
								n_agc_dis = !agc_dis_q;
								n_agc_act = 1'b0;
								n_busy    = 1'b0;
								n_btn     = '0;
								n_cnt     = '0;
							end
						end else begin
							n_cnt = h1;
						end
					end
				end
				BTN_MODE: begin
					if (cnt_q < d) begin
						if (pressed) begin
							n_cnt = cnt_inc;
						end else begin
							n_busy = 1'b0;
							n_btn  = '0;
							n_cnt  = '0;
						end
					end else if (cnt_q == d) begin
						if (!pressed)
							n_cnt = d1;
					end else if (cnt_q < w) begin
						if (pressed) begin
							n_cnt = w;
						end else begin
							n_cnt = cnt_inc;
							// no second press in time: single click
							if (cnt_inc >= w) begin
								mode_p = 1'b1;
								n_busy = 1'b0;
								n_btn  = '0;
								n_cnt  = '0;
							end
						end
					end else if (cnt_q < c) begin
						if (pressed) begin
							n_cnt = cnt_inc;
							if (cnt_inc >= c) begin
								theme_p = 1'b1;
								n_busy  = 1'b0;
								n_btn   = '0;
								n_cnt   = '0;
							end
						end else begin
							n_cnt = d1;
						end
					end
				end
				default: begin
					// source and EQ buttons: plain debounce
					if (pressed) begin
						n_cnt = cnt_inc;
						if (cnt_inc >= d) begin
							if (button_t'(btn_q) == BTN_SOURCE) begin
								case (src_q)
									SRC_USB: n_src = SRC_AUX;
									SRC_AUX: n_src = SRC_BT;
									default: n_src = SRC_USB;
								endcase
								chg = 1'b1;
							end else begin
								n_eq = !eq_q;
							end
							n_busy = 1'b0;
							n_btn  = '0;
							n_cnt  = '0;
						end
					end else begin
						n_busy = 1'b0;
						n_btn  = '0;
						n_cnt  = '0;
					end
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			btn_q     <= '0;
			cnt_q     <= '0;
			src_q     <= SRC_USB;
			eq_q      <= 1'b0;
			agc_dis_q <= 1'b1;
			agc_act_q <= 1'b0;
		end else if (en) begin
			busy_q    <= n_busy;
			btn_q     <= n_btn;
			cnt_q     <= n_cnt;
			src_q     <= n_src;
			eq_q      <= n_eq;
			agc_dis_q <= n_agc_dis;
			agc_act_q <= n_agc_act;
		end
	end

	// result shows the state after the transfer
	always_comb begin
		res.audio_source   = n_src;
		res.source_changed = chg;
		res.eq_enabled     = n_eq;
		res.agc_enabled    = !n_agc_dis;
		res.agc_run        = n_agc_act;
		res.next_mode      = mode_p;
		res.next_theme     = theme_p;
		res.busy_res       = n_busy;
	end

endmodule

### src/button_click_hold_double_detector_core.sv
// Top level of the four-button click, hold and double-click qualifier
//
// Takes one event (press edge or debounce tick) per clock when the input side does not stall, and
// returns one result per event. Each event passes the input register, then the state update that
// loads the result register. The qualifier state is updated combinationally from the input register,
// so back-to-back events sustain one transfer per cycle; the input side stalls only while the result
// register is full and out_stall is high.
`include "button_click_hold_double_detector_core_assert.svh"

module button_click_hold_double_detector_core (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	// event input
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [1:0] button,
	input  logic [3:0] levels,
	// result output
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] audio_source,
	output logic       source_changed,
	output logic       eq_enabled,
	output logic       agc_enabled,
	output logic       agc_run,
	output logic       next_mode,
	output logic       next_theme,
	output logic       busy_res
);
	import bcd_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    in_xfer;
	logic    advance;

	// handshake
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	bcd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.kind   <= kind;
			item_s1.button <= button;
			item_s1.levels <= levels;
		end
	end

	bcd_fsm u_fsm (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_comb;
	end

	assign out_valid      = valid_s2;
	assign audio_source   = res_s2.audio_source;
	assign source_changed = res_s2.source_changed;
	assign eq_enabled     = res_s2.eq_enabled;
	assign agc_enabled    = res_s2.agc_enabled;
	assign agc_run        = res_s2.agc_run;
	assign next_mode      = res_s2.next_mode;
	assign next_theme     = res_s2.next_theme;
	assign busy_res       = res_s2.busy_res;

	// checks
	`BCD_ASSERT(a_one_pulse, (out_valid |-> $onehot0({source_changed, next_mode, next_theme})), "more than one pulse in a result")
	`BCD_ASSERT(a_pulse_idle, (out_valid && (source_changed || next_mode || next_theme) |-> !busy_res), "pulse while still busy")
	`BCD_ASSERT(a_run_enabled, (out_valid && agc_run |-> agc_enabled), "agc_run while AGC disabled")
	`BCD_ASSERT_ALWAYS(a_stall_full, (in_stall |-> valid_s2 && out_stall), "input stalled with room in the result register")

endmodule

### tb/tb_button_click_hold_double_detector_core.sv
// Self-checking testbench of the button qualifier: scripted and random transfers vs. a predictor
module tb_button_click_hold_double_detector_core;
	import bcd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int N_STEPS = 31;

	// one row of the scripted part: a register write or an event transfer
	typedef struct packed {
		logic       is_cfg;
		reg_idx_t   idx;
		logic [9:0] val;
		logic       kind;
		logic [1:0] button;
		logic [3:0] levels;
		logic       typed;
		result_t    res;
	} step_t;

	localparam result_t IDLE_RES = '0;
	localparam result_t BUSY_RES = '{audio_source: SRC_USB, busy_res: 1'b1, default: '0};
	localparam result_t AUX_RES  = '{audio_source: SRC_AUX, source_changed: 1'b1, default: '0};

	// reset state, edge/tick while busy/idle, then every button under the tightest thresholds
	localparam step_t SCRIPT [N_STEPS] = '{
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'hF, 1'b1, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_EDGE, BTN_SOURCE, 4'h0, 1'b1, BUSY_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_EDGE, BTN_MODE,   4'hF, 1'b1, BUSY_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h0, 1'b1, IDLE_RES},
		'{1'b1, REG_DEBOUNCE,       10'd1, KIND_EDGE, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		'{1'b1, REG_HOLD,           10'd2, KIND_EDGE, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		'{1'b1, REG_DOUBLE_WAIT,    10'd3, KIND_EDGE, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		'{1'b1, REG_DOUBLE_CONFIRM, 10'd4, KIND_EDGE, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		// source click
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_EDGE, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h1, 1'b1, AUX_RES},
		// EQ click
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_EDGE, BTN_EQ,     4'h0, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'hF, 1'b0, IDLE_RES},
		// AGC double click switches AGC on
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_EDGE, BTN_AGC,    4'h0, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h4, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h4, 1'b0, IDLE_RES},
		// AGC long hold, release, then a second press switches AGC off
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_EDGE, BTN_AGC,    4'hF, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'hF, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'hF, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'hF, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h4, 1'b0, IDLE_RES},
		// mode single click
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_EDGE, BTN_MODE,   4'h0, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h8, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h0, 1'b0, IDLE_RES},
		// mode double click
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_EDGE, BTN_MODE,   4'h0, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h8, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h7, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'hF, 1'b0, IDLE_RES},
		'{1'b0, REG_DEBOUNCE, 10'd0, KIND_TICK, BTN_SOURCE, 4'h8, 1'b0, IDLE_RES}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [9:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       kind;
	logic [1:0] button;
	logic [3:0] levels;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] audio_source;
	logic       source_changed;
	logic       eq_enabled;
	logic       agc_enabled;
	logic       agc_run;
	logic       next_mode;
	logic       next_theme;
	logic       busy_res;

	// predictor copy of thresholds and qualifier state
	int      th_debounce = 50;
	int      th_hold     = 120;
	int      th_wait     = 450;
	int      th_confirm  = 500;
	bit      q_busy      = 1'b0;
	button_t q_btn       = BTN_SOURCE;
	int      q_count     = 0;
	logic [1:0] q_src    = SRC_USB;
	bit      q_eq        = 1'b0;
	bit      q_agc_off   = 1'b1;
	bit      q_agc_run   = 1'b0;
	bit      q_ignored;

	result_t status_due [$];
	result_t got_status;
	result_t due_status;
	int      errors = 0;
	int      n_sent = 0;
	int      n_useful = 0;
	int      gap_pct;
	int      stall_pct;
	int      quiet_cycles = 0;

	button_click_hold_double_detector_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void release_button();
		q_busy = 1'b0;
		q_btn = BTN_SOURCE;
		q_count = 0;
	endfunction

	// advance the qualifier by one event and return the status it reports
	function automatic result_t qualify(item_t it);
		result_t r;
		logic pressed;
		r = '0;
		q_ignored = (it.kind == KIND_EDGE) ? q_busy : !q_busy;
		if (it.kind == KIND_EDGE) begin
			if (!q_busy) begin
				q_busy = 1'b1;
				q_btn = button_t'(it.button);
				q_count = 0;
			end
		end else if (q_busy) begin
			pressed = it.levels[q_btn];
			case (q_btn)
				BTN_AGC: begin
					if (q_count < th_debounce) begin
						if (pressed) q_count++;
						else begin
							q_agc_run = 1'b0;
							release_button();
						end
					end else if (q_count < th_hold) begin
						if (pressed) begin
							q_count++;
							if (q_count >= th_hold && !q_agc_off) q_agc_run = 1'b1;
						end else begin
							q_agc_run = 1'b0;
							q_count = th_hold + 1;
						end
					end else if (q_count == th_hold) begin
						if (pressed) q_agc_run = !q_agc_off;
						else begin
							q_agc_run = 1'b0;
							q_count = th_hold + 1;
						end
					end else if (q_count < th_wait) begin
						if (pressed) q_count = th_wait;
						else begin
							q_count++;
							if (q_count >= th_wait) begin
								q_agc_run = 1'b0;
								release_button();
							end
						end
					end else if (q_count < th_confirm) begin
						if (pressed) begin
							q_count++;
							if (q_count >= th_confirm) begin
								q_agc_off = !q_agc_off;
								q_agc_run = 1'b0;
								release_button();
							end
						end else q_count = th_hold + 1;
					end
				end
				BTN_MODE: begin
					if (q_count < th_debounce) begin
						if (pressed) q_count++;
						else release_button();
					end else if (q_count == th_debounce) begin
						if (!pressed) q_count = th_debounce + 1;
					end else if (q_count < th_wait) begin
						if (pressed) q_count = th_wait;
						else begin
							q_count++;
							if (q_count >= th_wait) begin
								r.next_mode = 1'b1;
								release_button();
							end
						end
					end else if (q_count < th_confirm) begin
						if (pressed) begin
							q_count++;
							if (q_count >= th_confirm) begin
								r.next_theme = 1'b1;
								release_button();
							end
						end else q_count = th_debounce + 1;
					end
				end
				default: begin
					// source and EQ buttons: plain debounced click
					if (pressed) begin
						q_count++;
						if (q_count >= th_debounce) begin
							if (q_btn == BTN_SOURCE) begin
								q_src = (q_src == SRC_USB) ? SRC_AUX :
									(q_src == SRC_AUX) ? SRC_BT : SRC_USB;
								r.source_changed = 1'b1;
							end else q_eq = !q_eq;
							release_button();
						end
					end else release_button();
				end
			endcase
		end
		r.audio_source = q_src;
		r.eq_enabled = q_eq;
		r.agc_enabled = !q_agc_off;
		r.agc_run = q_agc_run;
		r.busy_res = q_busy;
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// drop valid and scramble the idle payload
	task automatic hold_off();
		@(negedge clk);
		in_valid <= 1'b0;
		kind <= 1'($urandom);
		button <= 2'($urandom);
		levels <= 4'($urandom);
	endtask

	// wait until every predicted status has come back
	task automatic drain();
		hold_off();
		while (status_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [9:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_DEBOUNCE:    th_debounce = int'(val[7:0]);
			REG_HOLD:        th_hold = int'(val[8:0]);
			REG_DOUBLE_WAIT: th_wait = int'(val);
			default:         th_confirm = int'(val);
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_thresholds(logic [9:0] deb, logic [9:0] hold, logic [9:0] dwait,
			logic [9:0] conf);
		drain();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_HOLD, hold);
		write_reg(REG_DOUBLE_WAIT, dwait);
		write_reg(REG_DOUBLE_CONFIRM, conf);
	endtask

	// one event transfer; the predicted status is queued at acceptance
	task automatic send(item_t it, bit typed = 1'b0, result_t typed_res = '0);
		result_t r;
		// each idle cycle is drawn on its own, so gap_pct is the idle share of cycles
		if ($urandom_range(0, 99) < gap_pct) begin
			hold_off();
			while ($urandom_range(0, 99) < gap_pct) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= it.kind;
		button <= it.button;
		levels <= it.levels;
		do @(posedge clk); while (in_stall);
		r = qualify(it);
		status_due.push_back(typed ? typed_res : r);
		n_sent++;
		if (!q_ignored) n_useful++;
	endtask

	// mostly press/release patterns on one button, some stray events
	task automatic run_phase(int budget);
		int stop_useful;
		int cap;
		int segs;
		int len;
		logic [1:0] b;
		logic pressed;
		item_t it;
		stop_useful = n_useful + budget;
		cap = n_sent + 3 * budget;
		while (n_useful < stop_useful && n_sent < cap) begin
			if ($urandom_range(0, 39) == 0) drain();
			if ($urandom_range(0, 9) < 8) begin
				b = 2'($urandom);
				it.kind = KIND_EDGE;
				it.button = b;
				it.levels = 4'($urandom);
				send(it);
				pressed = 1'b1;
				segs = $urandom_range(1, 6);
				while (segs > 0 && q_busy && n_sent < cap) begin
					case ($urandom_range(0, 5))
						0: len = $urandom_range(1, 3);
						1: len = th_debounce;
						2: len = $urandom_range(1, th_debounce + 2);
						3: len = $urandom_range(1, th_hold + 2);
						4: len = th_confirm - th_wait;
						default: len = $urandom_range(1, th_wait + 2);
					endcase
					if (len < 1) len = 1;
					while (len > 0 && q_busy && n_sent < cap) begin
						it.kind = ($urandom_range(0, 19) == 0) ? KIND_EDGE : KIND_TICK;
						it.button = 2'($urandom);
						it.levels = 4'($urandom);
						it.levels[b] = pressed;
						send(it);
						len--;
					end
					pressed = !pressed;
					segs--;
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					it.kind = 1'($urandom);
					it.button = 2'($urandom);
					it.levels = 4'($urandom);
					send(it);
				end
			end
		end
	endtask

	// receiver stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// status checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_status = {audio_source, source_changed, eq_enabled, agc_enabled, agc_run,
				next_mode, next_theme, busy_res};
			if (status_due.size() == 0) begin
				$error("status transfer with nothing outstanding: %h", got_status);
				errors++;
			end else begin
				due_status = status_due.pop_front();
				check_field("audio_source", due_status.audio_source, got_status.audio_source);
				check_field("source_changed", due_status.source_changed,
					got_status.source_changed);
				check_field("eq_enabled", due_status.eq_enabled, got_status.eq_enabled);
				check_field("agc_enabled", due_status.agc_enabled, got_status.agc_enabled);
				check_field("agc_run", due_status.agc_run, got_status.agc_run);
				check_field("next_mode", due_status.next_mode, got_status.next_mode);
				check_field("next_theme", due_status.next_theme, got_status.next_theme);
				check_field("busy_res", due_status.busy_res, got_status.busy_res);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("button_click_hold_double_detector_core: mismatch");
			$finish;
		end
	end

	initial begin
		item_t it;
		int d;
		int h;
		int w;
		int c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_EDGE;
		button = '0;
		levels = '0;
		out_stall = 1'b0;
		gap_pct = 11;
		stall_pct = 58;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// scripted part
		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].is_cfg) begin
				drain();
				write_reg(SCRIPT[i].idx, SCRIPT[i].val);
			end else begin
				it.kind = SCRIPT[i].kind;
				it.button = SCRIPT[i].button;
				it.levels = SCRIPT[i].levels;
				send(it, SCRIPT[i].typed, SCRIPT[i].res);
			end
		end

		// small ordered thresholds
		set_thresholds(10'd3, 10'd8, 10'd14, 10'd18);
		run_phase(380);

		gap_pct = 58;
		stall_pct = 11;
		// zero debounce
		set_thresholds(10'd0, 10'd2, 10'd5, 10'd7);
		run_phase(200);

		// random ordered thresholds, junk in the unused upper data bits
		d = $urandom_range(1, 6);
		h = d + $urandom_range(1, 10);
		w = h + $urandom_range(1, 12);
		c = w + $urandom_range(1, 8);
		set_thresholds({2'($urandom), 8'(d)}, {1'($urandom), 9'(h)}, 10'(w), 10'(c));
		run_phase(300);

		gap_pct = 0;
		stall_pct = 0;
		// largest thresholds
		set_thresholds(10'd255, 10'd511, 10'd1022, 10'd1023);
		run_phase(280);

		// misordered thresholds, may leave the qualifier stuck busy
		d = $urandom_range(6, 12);
		h = $urandom_range(2, 5);
		w = $urandom_range(3, 8);
		c = $urandom_range(4, 10);
		set_thresholds(10'(d), 10'(h), 10'(w), 10'(c));
		run_phase(150);

		hold_off();
		while (status_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("button_click_hold_double_detector_core: match");
		else $display("button_click_hold_double_detector_core: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/bcd_pkg.sv
src/bcd_cfg.sv
src/bcd_fsm.sv
src/button_click_hold_double_detector_core.sv
tb/tb_button_click_hold_double_detector_core.sv
